>>> src/tbt_pkg.sv
// ============================================================================
// Thread boost table package
// Widths, codes, types and clamp constants shared by the thread boost table.
// ============================================================================
package tbt_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int TID_W      = 22;
    localparam int BOOST_W    = 16;
    localparam int STATUS_W   = 3;
    localparam int CLAMP_W    = 11;
    localparam int OCC_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEVEL_ONE   = 2'd0,
        CFG_LEVEL_TWO   = 2'd1,
        CFG_LEVEL_THREE = 2'd2,
        CFG_CLAMP_EN    = 2'd3
    } t_cfg_idx;

    localparam logic [BOOST_W-1:0] RST_LEVEL_ONE   = 16'd25;
    localparam logic [BOOST_W-1:0] RST_LEVEL_TWO   = 16'd50;
    localparam logic [BOOST_W-1:0] RST_LEVEL_THREE = 16'd75;
    localparam logic               RST_CLAMP_EN    = 1'b1;

    // Utilization clamp pairs, one per boost band.
    localparam logic [CLAMP_W-1:0] PERF_MIN    = 11'd512;
    localparam logic [CLAMP_W-1:0] PERF_MAX    = 11'd1024;
    localparam logic [CLAMP_W-1:0] MOD_MIN     = 11'd256;
    localparam logic [CLAMP_W-1:0] MOD_MAX     = 11'd768;
    localparam logic [CLAMP_W-1:0] SUST_MIN    = 11'd0;
    localparam logic [CLAMP_W-1:0] SUST_MAX    = 11'd512;
    localparam logic [CLAMP_W-1:0] DEFAULT_MIN = 11'd0;
    localparam logic [CLAMP_W-1:0] DEFAULT_MAX = 11'd1024;

    typedef enum logic [STATUS_W-1:0] {
        ST_UPDATED     = 3'd0,
        ST_UNCHANGED   = 3'd1,
        ST_INSERTED    = 3'd2,
        ST_FULL        = 3'd3,
        ST_LOOKUP_HIT  = 3'd4,
        ST_LOOKUP_MISS = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_DECIDE,
        S_SH_READ,
        S_SH_WRITE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [TID_W-1:0]   thread_id;
        logic [BOOST_W-1:0] boost;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [BOOST_W-1:0] level_one;
        logic [BOOST_W-1:0] level_two;
        logic [BOOST_W-1:0] level_three;
        logic               clamp_en;
    } t_cfg;

    typedef struct packed {
        logic               kind;
        logic [TID_W-1:0]   thread_id;
        logic [BOOST_W-1:0] boost;
    } t_req;

    typedef struct packed {
        logic [CLAMP_W-1:0] cmin;
        logic [CLAMP_W-1:0] cmax;
    } t_clamp;

    typedef struct packed {
        t_status            status;
        logic [BOOST_W-1:0] boost_value;
        logic               apply_clamp;
        logic [CLAMP_W-1:0] clamp_min;
        logic [CLAMP_W-1:0] clamp_max;
        logic               entry_removed;
        logic [OCC_W-1:0]   occupancy;
    } t_result;

endpackage

>>> src/tbt_req_if.sv
// ============================================================================
// Thread boost table request channel
// Valid/ready channel carrying one update or lookup beat.
// ============================================================================
interface tbt_req_if;
    import tbt_pkg::*;

    logic               valid;
    logic               ready;
    logic               kind;
    logic [TID_W-1:0]   thread_id;
    logic [BOOST_W-1:0] boost;

    modport source (output valid, kind, thread_id, boost, input ready);
    modport sink   (input valid, kind, thread_id, boost, output ready);
endinterface

>>> src/tbt_rsp_if.sv
// ============================================================================
// Thread boost table response channel
// Valid/ready channel carrying one result beat per request.
// ============================================================================
interface tbt_rsp_if;
    import tbt_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [BOOST_W-1:0]  boost_value;
    logic                apply_clamp;
    logic [CLAMP_W-1:0]  clamp_min;
    logic [CLAMP_W-1:0]  clamp_max;
    logic                entry_removed;
    logic [OCC_W-1:0]    occupancy;

    modport source (output valid, status, boost_value, apply_clamp, clamp_min, clamp_max,
                    entry_removed, occupancy, input ready);
    modport sink   (input valid, status, boost_value, apply_clamp, clamp_min, clamp_max,
                    entry_removed, occupancy, output ready);
endinterface

>>> src/thread_boost_table.sv
// ============================================================================
// Thread boost table
// Fixed-depth table of thread id / boost pairs with clamp selection.
// ============================================================================
// One request beat is taken at a time; ready stays low until its result has
// been handed to the output register. The entries live in a RAM with one read
// and one write port and registered read, checked by one comparator, so each
// entry examined in a search passes through a read state and a compare state;
// a hit stops the search and a miss examines all valid entries. A decide
// state and a done state then hand over the result, and a removal that has to
// close a gap adds a read and a write state for every later entry moved down.
// An update for a new thread on a full table is dropped and reported.
// The result register lets the next request start while a result waits.
module thread_boost_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tbt_req_if.sink                       i_req,
    tbt_rsp_if.source                     o_rsp,
    input  logic                          i_cfg_we,
    input  logic [tbt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tbt_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import tbt_pkg::*;

    t_cfg    r_cfg;
    t_req    req;
    t_result res;
    t_result r_out;
    logic    r_out_valid;
    logic    res_valid;
    logic    res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.level_one   <= RST_LEVEL_ONE;
            r_cfg.level_two   <= RST_LEVEL_TWO;
            r_cfg.level_three <= RST_LEVEL_THREE;
            r_cfg.clamp_en    <= RST_CLAMP_EN;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_LEVEL_ONE:   r_cfg.level_one   <= i_cfg_wdata;
                CFG_LEVEL_TWO:   r_cfg.level_two   <= i_cfg_wdata;
                CFG_LEVEL_THREE: r_cfg.level_three <= i_cfg_wdata;
                CFG_CLAMP_EN:    r_cfg.clamp_en    <= i_cfg_wdata[0];
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    assign req = '{kind: i_req.kind, thread_id: i_req.thread_id, boost: i_req.boost};

    tbt_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_req       (req),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    assign res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out.status;
    assign o_rsp.boost_value   = r_out.boost_value;
    assign o_rsp.apply_clamp   = r_out.apply_clamp;
    assign o_rsp.clamp_min     = r_out.clamp_min;
    assign o_rsp.clamp_max     = r_out.clamp_max;
    assign o_rsp.entry_removed = r_out.entry_removed;
    assign o_rsp.occupancy     = r_out.occupancy;
endmodule

>>> src/tbt_ram.sv
// ============================================================================
// Generic RAM
// One write port and one read port with registered read data.
// ============================================================================
module tbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> src/tbt_clamp.sv
// ============================================================================
// Thread boost table clamp selector
// Maps a boost level onto a utilization clamp pair through three thresholds.
// ============================================================================
module tbt_clamp (
    input  tbt_pkg::t_cfg                   i_cfg,
    input  logic [tbt_pkg::BOOST_W-1:0]     i_boost,
    output tbt_pkg::t_clamp                 o_clamp
);
    import tbt_pkg::*;

    // Highest band is tested first; thresholds out of order are used as given.
    always_comb begin
        if (i_boost >= i_cfg.level_three) begin
            o_clamp = '{cmin: PERF_MIN, cmax: PERF_MAX};
        end else if (i_boost >= i_cfg.level_two) begin
            o_clamp = '{cmin: MOD_MIN, cmax: MOD_MAX};
        end else if (i_boost >= i_cfg.level_one) begin
            o_clamp = '{cmin: SUST_MIN, cmax: SUST_MAX};
        end else begin
            o_clamp = '{cmin: DEFAULT_MIN, cmax: DEFAULT_MAX};
        end
    end
endmodule

>>> src/tbt_engine.sv
// ============================================================================
// Thread boost table engine
// Sequencer that searches, updates, appends and compacts the entry RAM.
// ============================================================================
module tbt_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tbt_pkg::t_cfg    i_cfg,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  tbt_pkg::t_req    i_req,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output tbt_pkg::t_result o_res
);
    import tbt_pkg::*;

    t_state              r_state, n_state;
    logic                r_kind, n_kind;
    logic [TID_W-1:0]    r_tid, n_tid;
    logic [BOOST_W-1:0]  r_boost, n_boost;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [IDX_W-1:0]    r_slot, n_slot;
    logic                r_hit, n_hit;
    logic [BOOST_W-1:0]  r_old, n_old;
    logic [CNT_W-1:0]    r_count, n_count;
    t_status             r_status, n_status;
    logic [BOOST_W-1:0]  r_value, n_value;
    logic                r_apply, n_apply;
    logic [CLAMP_W-1:0]  r_cmin, n_cmin;
    logic [CLAMP_W-1:0]  r_cmax, n_cmax;
    logic                r_removed, n_removed;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    t_entry              ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;
    t_entry              rd_entry;
    t_clamp              clamp;

    logic                changed;
    logic [IDX_W-1:0]    sel_slot;
    logic [CNT_W-1:0]    cnt_after;

    assign rd_entry = t_entry'(ram_rdata);

    tbt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    tbt_clamp u_clamp (
        .i_cfg   (i_cfg),
        .i_boost (r_boost),
        .o_clamp (clamp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_kind    <= n_kind;
        r_tid     <= n_tid;
        r_boost   <= n_boost;
        r_idx     <= n_idx;
        r_slot    <= n_slot;
        r_hit     <= n_hit;
        r_old     <= n_old;
        r_status  <= n_status;
        r_value   <= n_value;
        r_apply   <= n_apply;
        r_cmin    <= n_cmin;
        r_cmax    <= n_cmax;
        r_removed <= n_removed;
    end

    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_tid     = r_tid;
        n_boost   = r_boost;
        n_idx     = r_idx;
        n_slot    = r_slot;
        n_hit     = r_hit;
        n_old     = r_old;
        n_count   = r_count;
        n_status  = r_status;
        n_value   = r_value;
        n_apply   = r_apply;
        n_cmin    = r_cmin;
        n_cmax    = r_cmax;
        n_removed = r_removed;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = '{thread_id: r_tid, boost: r_boost};
        changed   = 1'b0;
        sel_slot  = r_slot;
        cnt_after = r_count;
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_kind  = i_req.kind;
                    n_tid   = i_req.thread_id;
                    n_boost = i_req.boost;
                    n_idx   = '0;
                    n_hit   = 1'b0;
                    n_old   = '0;
                    n_state = (r_count == '0) ? S_DECIDE : S_READ;
                end
            end
            S_READ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (rd_entry.thread_id == r_tid) begin
                    n_hit   = 1'b1;
                    n_slot  = r_idx;
                    n_old   = rd_entry.boost;
                    n_state = S_DECIDE;
                end else if (CNT_W'(r_idx) + CNT_W'(1) == r_count) begin
                    n_state = S_DECIDE;
                end else begin
                    n_idx   = IDX_W'(r_idx + 1'b1);
                    n_state = S_READ;
                end
            end
            S_DECIDE: begin
                n_value   = '0;
                n_apply   = 1'b0;
                n_cmin    = '0;
                n_cmax    = '0;
                n_removed = 1'b0;
                n_state   = S_DONE;
                if (r_kind == KIND_LOOKUP) begin
                    n_status = r_hit ? ST_LOOKUP_HIT : ST_LOOKUP_MISS;
                    n_value  = r_hit ? r_old : '0;
                end else if (r_hit && (r_old == r_boost)) begin
                    n_status = ST_UNCHANGED;
                end else if (r_hit) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_slot;
                    n_status  = ST_UPDATED;
                    changed   = 1'b1;
                end else if (r_count == CNT_W'(TABLE_DEPTH)) begin
                    n_status = ST_FULL;
                end else begin
                    sel_slot  = IDX_W'(r_count);
                    cnt_after = r_count + CNT_W'(1);
                    ram_we    = 1'b1;
                    ram_waddr = sel_slot;
                    n_slot    = sel_slot;
                    n_count   = cnt_after;
                    n_status  = ST_INSERTED;
                    changed   = 1'b1;
                end

                if (changed) begin
                    n_apply = i_cfg.clamp_en;
                    n_cmin  = i_cfg.clamp_en ? clamp.cmin : '0;
                    n_cmax  = i_cfg.clamp_en ? clamp.cmax : '0;
                    if (r_boost == '0) begin
                        n_removed = 1'b1;
                        // Later entries move down one place to keep the table packed.
                        if (CNT_W'(sel_slot) + CNT_W'(1) < cnt_after) begin
                            n_idx   = IDX_W'(sel_slot + 1'b1);
                            n_state = S_SH_READ;
                        end else begin
                            n_count = cnt_after - CNT_W'(1);
                        end
                    end
                end
            end
            S_SH_READ: begin
                n_state = S_SH_WRITE;
            end
            S_SH_WRITE: begin
                ram_we    = 1'b1;
                ram_waddr = IDX_W'(r_idx - 1'b1);
                ram_wdata = rd_entry;
                if (CNT_W'(r_idx) + CNT_W'(1) < r_count) begin
                    n_idx   = IDX_W'(r_idx + 1'b1);
                    n_state = S_SH_READ;
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res = '{
        status:        r_status,
        boost_value:   r_value,
        apply_clamp:   r_apply,
        clamp_min:     r_cmin,
        clamp_max:     r_cmax,
        entry_removed: r_removed,
        occupancy:     OCC_W'(r_count)
    };
endmodule

>>> src/tbt_checker.sv
// ============================================================================
// Thread boost table checker
// Port-level properties of the result channel, bound to the top level.
// ============================================================================
module tbt_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_rsp_valid,
    input logic                           i_rsp_ready,
    input logic [tbt_pkg::STATUS_W-1:0]    i_status,
    input logic [tbt_pkg::BOOST_W-1:0]     i_boost_value,
    input logic                           i_apply_clamp,
    input logic [tbt_pkg::CLAMP_W-1:0]     i_clamp_min,
    input logic [tbt_pkg::CLAMP_W-1:0]     i_clamp_max,
    input logic                           i_entry_removed,
    input logic [tbt_pkg::OCC_W-1:0]       i_occupancy
);
    import tbt_pkg::*;

    // A stalled result beat keeps its contents.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_status)
            && $stable(i_boost_value) && $stable(i_occupancy))
        else $error("result beat changed while stalled");

    // Lookups never carry clamp or removal information.
    a_lookup_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_status == ST_LOOKUP_HIT || i_status == ST_LOOKUP_MISS)
            |-> !i_apply_clamp && !i_entry_removed && i_clamp_min == '0 && i_clamp_max == '0)
        else $error("lookup result carries clamp or removal");

    // Only a change of the table can remove an entry.
    a_remove_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_entry_removed |-> (i_status == ST_UPDATED || i_status == ST_INSERTED))
        else $error("removal reported for an unchanged table");

    // An applied clamp pair is ordered and has a nonzero ceiling.
    a_clamp_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_apply_clamp |-> i_clamp_min < i_clamp_max)
        else $error("clamp pair out of order");

    // Every result but a lookup hit reports a zero value.
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_status != ST_LOOKUP_HIT |-> i_boost_value == '0)
        else $error("boost value set outside a lookup hit");
endmodule

bind thread_boost_table tbt_checker u_tbt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_status        (o_rsp.status),
    .i_boost_value   (o_rsp.boost_value),
    .i_apply_clamp   (o_rsp.apply_clamp),
    .i_clamp_min     (o_rsp.clamp_min),
    .i_clamp_max     (o_rsp.clamp_max),
    .i_entry_removed (o_rsp.entry_removed),
    .i_occupancy     (o_rsp.occupancy)
);
